### design/ejst_pkg.sv
package ejst_pkg;

   // field widths of the record and result words
   localparam int TAG_BITS    = 8;
   localparam int IN_KEY_BITS = 12;
   localparam int DELTA_BITS  = 16;
   localparam int TOTAL_BITS  = 64;

   // defaults for the table geometry
   localparam int DEF_KEY_BITS   = 12;
   localparam int DEF_COUNT_BITS = 32;

   // shared multiplier slices the operand into chunks, top chunk first
   localparam int CHUNK_BITS = 16;
   localparam int CHUNKS     = TOTAL_BITS / CHUNK_BITS;
   localparam int STEP_BITS  = $clog2(CHUNKS);
   localparam int PROD_BITS  = CHUNK_BITS + DELTA_BITS + 2;

   // configuration port
   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = 8;

   typedef logic [CSR_IDX_BITS-1:0] csr_idx_type;

   localparam csr_idx_type CSR_JOIN_MODE     = 2'd0;
   localparam csr_idx_type CSR_FIRST_STREAM  = 2'd1;
   localparam csr_idx_type CSR_SECOND_STREAM = 2'd2;

   // register reset values
   localparam logic [TAG_BITS-1:0] FIRST_STREAM_RST  = 8'd0;
   localparam logic [TAG_BITS-1:0] SECOND_STREAM_RST = 8'd1;

endpackage

### design/ejst_ram.sv
module ejst_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

### design/exact_join_size_tracker_top.sv
// exact join / self-join size tracker
//
// req_ channel: one word per record (stream tag, key, signed delta), valid/ready.
// rsp_ channel: one word per record, the running size total after the record
// and a flag that tells whether the record matched a configured stream.
// csr_ port: write-only registers (join mode, first stream id, second stream id),
// to be written only while no record is in flight; not enforced by the block.
//
// A matching record goes through these steps after acceptance: one in which
// the counter read returns and the operand is formed, four passes of the
// shared 17x17 multiplier (one 16-bit slice of the 64-bit operand each) and
// one to update the total and write the counter back. The block takes one
// record at a time and is ready again the cycle after its final step, so it
// cannot take a new record before it is through with the last one. A record
// that matches no stream skips the load and the multiply steps.
// The result sits in an output register; a new record is taken while it waits,
// and that record holds in its final step until the receiver takes the old one.
// After reset both key tables are swept to zero, one entry per cycle, over all
// 2**KEY_BITS entries; req_ready stays low meanwhile, csr writes are taken.
module exact_join_size_tracker_top
   import ejst_pkg::*;
#(
   parameter int KEY_BITS   = DEF_KEY_BITS,
   parameter int COUNT_BITS = DEF_COUNT_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   // record input
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [TAG_BITS-1:0]           req_stream_tag,
   input  logic [IN_KEY_BITS-1:0]        req_item_key,
   input  logic signed [DELTA_BITS-1:0]  req_delta,
   // result output
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [TOTAL_BITS-1:0]  rsp_size_estimate,
   output logic                          rsp_record_used,
   // configuration
   input  logic                          csr_write_en,
   input  logic [CSR_IDX_BITS-1:0]       csr_index,
   input  logic [CSR_DATA_BITS-1:0]      csr_wdata
);

   localparam int DEPTH = 2 ** KEY_BITS;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_LOAD = 2'd1;
   localparam logic [1:0] S_MUL  = 2'd2;
   localparam logic [1:0] S_DONE = 2'd3;

   // configuration registers
   logic                join_mode_ff;
   logic [TAG_BITS-1:0] first_stream_ff;
   logic [TAG_BITS-1:0] second_stream_ff;

   // control
   logic [1:0]           state_ff, state_in;
   logic                 clear_busy_ff, clear_busy_in;
   logic [KEY_BITS-1:0]  clear_addr_ff, clear_addr_in;
   logic [STEP_BITS-1:0] step_ff, step_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   // item context
   logic [KEY_BITS-1:0]          key_ff, key_in;
   logic signed [DELTA_BITS-1:0] delta_ff, delta_in;
   logic                         own_first_ff, own_first_in;
   logic                         used_ff, used_in;

   // datapath
   logic [TOTAL_BITS-1:0]        op_ff, op_in;
   logic [TOTAL_BITS-1:0]        acc_ff, acc_in;
   logic [COUNT_BITS-1:0]        count_ff, count_in;
   logic [TOTAL_BITS-1:0]        total_ff, total_in;
   logic signed [TOTAL_BITS-1:0] rsp_size_ff, rsp_size_in;
   logic                         rsp_used_ff, rsp_used_in;

   // table ports
   logic                  req_accept;
   logic                  first_wr_en, second_wr_en;
   logic [KEY_BITS-1:0]   wr_addr;
   logic [COUNT_BITS-1:0] wr_data;
   logic [KEY_BITS-1:0]   rd_addr;
   logic [COUNT_BITS-1:0] first_rd, second_rd;

   // matching and arithmetic helpers
   logic                         match_first, match_second;
   logic [TOTAL_BITS-1:0]        first_x, second_x, delta_x;
   logic signed [CHUNK_BITS:0]   chunk_s;
   logic signed [DELTA_BITS:0]   delta_s;
   logic signed [PROD_BITS-1:0]  prod;
   logic [TOTAL_BITS-1:0]        prod_x;
   logic                         finish;

   assign req_ready  = !clear_busy_ff && (state_ff == S_IDLE);
   assign req_accept = req_valid && req_ready;
   assign rd_addr    = KEY_BITS'(req_item_key);

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_size_estimate = rsp_size_ff;
   assign rsp_record_used   = rsp_used_ff;

   // stream matching: first stream wins when both ids agree
   assign match_first  = (req_stream_tag == first_stream_ff);
   assign match_second = join_mode_ff && (req_stream_tag == second_stream_ff) && !match_first;

   // sign-extended counters and delta
   assign first_x  = TOTAL_BITS'($signed(first_rd));
   assign second_x = TOTAL_BITS'($signed(second_rd));
   assign delta_x  = TOTAL_BITS'(delta_ff);

   // shared multiplier: unsigned operand slice times signed delta
   assign chunk_s = $signed({1'b0, op_ff[TOTAL_BITS-1 -: CHUNK_BITS]});
   assign delta_s = {delta_ff[DELTA_BITS-1], delta_ff};
   assign prod    = chunk_s * delta_s;
   assign prod_x  = TOTAL_BITS'(prod);

   assign finish = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_ready);

   // table write port: clearing sweep or counter write-back
   always_comb begin
      if (clear_busy_ff) begin
         first_wr_en  = 1'b1;
         second_wr_en = 1'b1;
         wr_addr      = clear_addr_ff;
         wr_data      = '0;
      end else begin
         first_wr_en  = finish && used_ff && own_first_ff;
         second_wr_en = finish && used_ff && !own_first_ff;
         wr_addr      = key_ff;
         wr_data      = count_ff;
      end
   end

   // sequencer and datapath next values
   always_comb begin
      state_in      = state_ff;
      clear_busy_in = clear_busy_ff;
      clear_addr_in = clear_addr_ff;
      step_in       = step_ff;
      rsp_valid_in  = rsp_valid_ff;
      key_in        = key_ff;
      delta_in      = delta_ff;
      own_first_in  = own_first_ff;
      used_in       = used_ff;
      op_in         = op_ff;
      acc_in        = acc_ff;
      count_in      = count_ff;
      total_in      = total_ff;
      rsp_size_in   = rsp_size_ff;
      rsp_used_in   = rsp_used_ff;

      // clearing sweep after reset
      if (clear_busy_ff) begin
         clear_addr_in = clear_addr_ff + 1'b1;
         if (clear_addr_ff == KEY_BITS'(DEPTH - 1)) begin
            clear_busy_in = 1'b0;
         end
      end

      // output word leaves
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               key_in       = rd_addr;
               delta_in     = req_delta;
               own_first_in = match_first;
               used_in      = match_first || match_second;
               acc_in       = '0;
               state_in     = (match_first || match_second) ? S_LOAD : S_DONE;
            end
         end
         S_LOAD: begin
            step_in = '0;
            if (!join_mode_ff) begin
               op_in    = (first_x << 1) + delta_x;
               count_in = first_rd + COUNT_BITS'(delta_ff);
            end else if (own_first_ff) begin
               op_in    = second_x;
               count_in = first_rd + COUNT_BITS'(delta_ff);
            end else begin
               op_in    = first_x;
               count_in = second_rd + COUNT_BITS'(delta_ff);
            end
            state_in = S_MUL;
         end
         S_MUL: begin
            // horner over the slices, top slice first
            acc_in  = (acc_ff << CHUNK_BITS) + prod_x;
            op_in   = op_ff << CHUNK_BITS;
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_BITS'(CHUNKS - 1)) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (finish) begin
               total_in     = total_ff + acc_ff;
               rsp_size_in  = $signed(total_ff + acc_ff);
               rsp_used_in  = used_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         clear_busy_ff <= 1'b1;
         clear_addr_ff <= '0;
         rsp_valid_ff  <= 1'b0;
         total_ff      <= '0;
      end else begin
         state_ff      <= state_in;
         clear_busy_ff <= clear_busy_in;
         clear_addr_ff <= clear_addr_in;
         rsp_valid_ff  <= rsp_valid_in;
         total_ff      <= total_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      step_ff      <= step_in;
      key_ff       <= key_in;
      delta_ff     <= delta_in;
      own_first_ff <= own_first_in;
      used_ff      <= used_in;
      op_ff        <= op_in;
      acc_ff       <= acc_in;
      count_ff     <= count_in;
      rsp_size_ff  <= rsp_size_in;
      rsp_used_ff  <= rsp_used_in;
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         join_mode_ff     <= 1'b0;
         first_stream_ff  <= FIRST_STREAM_RST;
         second_stream_ff <= SECOND_STREAM_RST;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_JOIN_MODE:     join_mode_ff     <= csr_wdata[0];
            CSR_FIRST_STREAM:  first_stream_ff  <= csr_wdata[TAG_BITS-1:0];
            CSR_SECOND_STREAM: second_stream_ff <= csr_wdata[TAG_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   // per-key counter tables
   ejst_ram #(
      .WIDTH (COUNT_BITS),
      .DEPTH (DEPTH)
   ) u_first_counts (
      .clock   (clock),
      .wr_en   (first_wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (req_accept),
      .rd_addr (rd_addr),
      .rd_data (first_rd)
   );

   ejst_ram #(
      .WIDTH (COUNT_BITS),
      .DEPTH (DEPTH)
   ) u_second_counts (
      .clock   (clock),
      .wr_en   (second_wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (req_accept),
      .rd_addr (rd_addr),
      .rd_data (second_rd)
   );

endmodule
